// ===== rtl/spadd_pkg.sv =====
package spadd_pkg;

    // Buffer geometry.
    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    // Field widths.
    localparam int COEFF_W = 32;
    localparam int POWER_W = 32;
    localparam int SUM_W   = COEFF_W + 1;

    // Input word kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Polynomial select.
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INPUT = 2'd1;
    localparam logic [1:0] ERR_OVF   = 2'd2;

    // One stored term.
    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic signed [POWER_W-1:0] power;
    } spadd_term_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       start;
        logic       step;
        logic       finish;
        logic       fail;
        logic [1:0] fail_code;
    } spadd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic overflow;
        logic bad_input;
        logic merge_done;
        logic out_free;
    } spadd_status_t;

endpackage

// ===== rtl/spadd_ctrl.sv =====
module spadd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  spadd_pkg::spadd_status_t status,
    output spadd_pkg::spadd_cmd_t    cmd
);
    import spadd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FETCH   = 6'b000010,
        ST_MERGE   = 6'b000100,
        ST_FINAL   = 6'b001000,
        ST_ERR_IN  = 6'b010000,
        ST_ERR_OVF = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input words are taken only while no run is in progress.
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.fail_code = ERR_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_LOAD))
                begin
                    cmd.load = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start = 1'b1;
                    if (status.overflow)
                    begin
                        state_next = ST_ERR_OVF;
                    end
                    else if (status.bad_input)
                    begin
                        state_next = ST_ERR_IN;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                // Buffer read data lands at the end of this cycle.
                if (status.merge_done)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (status.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR_IN:
            begin
                if (status.out_free)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ERR_INPUT;
                    state_next    = ST_IDLE;
                end
            end
            ST_ERR_OVF:
            begin
                if (status.out_free)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ERR_OVF;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/spadd_dp.sv =====
module spadd_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  poly_sel,
    input  logic signed [spadd_pkg::COEFF_W-1:0]  coeff,
    input  logic signed [spadd_pkg::POWER_W-1:0]  power,
    input  spadd_pkg::spadd_cmd_t                 cmd,
    output spadd_pkg::spadd_status_t              status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [spadd_pkg::SUM_W-1:0]    coeff_sum,
    output logic signed [spadd_pkg::POWER_W-1:0]  power_out,
    output logic                                  has_term,
    output logic [1:0]                            error,
    output logic                                  last
);
    import spadd_pkg::*;

    // Term buffers.
    spadd_term_t mem_a [MAX_TERMS];
    spadd_term_t mem_b [MAX_TERMS];
    spadd_term_t rd_a_reg;
    spadd_term_t rd_b_reg;

    // Load bookkeeping.
    logic [CNT_W-1:0]          count_a_reg;
    logic [CNT_W-1:0]          count_b_reg;
    logic                      overflow_reg;
    logic                      unordered_reg;
    logic signed [POWER_W-1:0] last_pow_a_reg;
    logic signed [POWER_W-1:0] last_pow_b_reg;

    // Merge indices and the held-back term.
    logic [CNT_W-1:0]          ia_reg;
    logic [CNT_W-1:0]          ib_reg;
    logic                      pend_valid_reg;
    logic signed [SUM_W-1:0]   pend_coeff_reg;
    logic signed [POWER_W-1:0] pend_power_reg;

    // Output word register.
    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   out_coeff_reg;
    logic signed [POWER_W-1:0] out_power_reg;
    logic                      out_has_reg;
    logic [1:0]                out_err_reg;
    logic                      out_last_reg;

    logic                      load_a;
    logic                      load_b;
    logic                      a_left;
    logic                      b_left;
    logic                      pow_eq;
    logic                      a_lt;
    logic                      take_a;
    logic                      take_b;
    logic signed [SUM_W-1:0]   ext_a;
    logic signed [SUM_W-1:0]   ext_b;
    logic signed [SUM_W-1:0]   cand_coeff;
    logic signed [POWER_W-1:0] cand_power;
    logic                      cand_valid;
    logic                      push_pend;
    logic                      clear;

    assign load_a = cmd.load && (poly_sel == SEL_A);
    assign load_b = cmd.load && (poly_sel == SEL_B);
    assign clear  = cmd.finish || cmd.fail;

    // Buffer write on load, registered read at the merge indices.
    always_ff @(posedge clk)
    begin
        if (load_a && (count_a_reg < CNT_W'(MAX_TERMS)))
        begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= '{coeff: coeff, power: power};
        end
        if (load_b && (count_b_reg < CNT_W'(MAX_TERMS)))
        begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= '{coeff: coeff, power: power};
        end
        rd_a_reg <= mem_a[ia_reg[ADDR_W-1:0]];
        rd_b_reg <= mem_b[ib_reg[ADDR_W-1:0]];
    end

    // Counts, overflow and an order check against the last stored power.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            overflow_reg  <= 1'b0;
            unordered_reg <= 1'b0;
        end
        else if (clear)
        begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            overflow_reg  <= 1'b0;
            unordered_reg <= 1'b0;
        end
        else if (load_a)
        begin
            if (count_a_reg < CNT_W'(MAX_TERMS))
            begin
                count_a_reg <= count_a_reg + CNT_W'(1);
                if ((count_a_reg != '0) && (power < last_pow_a_reg))
                begin
                    unordered_reg <= 1'b1;
                end
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
        else if (load_b)
        begin
            if (count_b_reg < CNT_W'(MAX_TERMS))
            begin
                count_b_reg <= count_b_reg + CNT_W'(1);
                if ((count_b_reg != '0) && (power < last_pow_b_reg))
                begin
                    unordered_reg <= 1'b1;
                end
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // Last stored power of each buffer.
    always_ff @(posedge clk)
    begin
        if (load_a && (count_a_reg < CNT_W'(MAX_TERMS)))
        begin
            last_pow_a_reg <= power;
        end
        if (load_b && (count_b_reg < CNT_W'(MAX_TERMS)))
        begin
            last_pow_b_reg <= power;
        end
    end

    // Merge compare: pick the lower power, add when the powers match.
    assign a_left = (ia_reg < count_a_reg);
    assign b_left = (ib_reg < count_b_reg);
    assign pow_eq = (rd_a_reg.power == rd_b_reg.power);
    assign a_lt   = (rd_a_reg.power < rd_b_reg.power);
    assign take_a = a_left && (!b_left || a_lt || pow_eq);
    assign take_b = b_left && (!a_left || !a_lt);
    assign ext_a  = {rd_a_reg.coeff[COEFF_W-1], rd_a_reg.coeff};
    assign ext_b  = {rd_b_reg.coeff[COEFF_W-1], rd_b_reg.coeff};

    always_comb
    begin
        if (take_a && take_b)
        begin
            cand_coeff = ext_a + ext_b;
        end
        else if (take_a)
        begin
            cand_coeff = ext_a;
        end
        else
        begin
            cand_coeff = ext_b;
        end
        cand_power = take_a ? rd_a_reg.power : rd_b_reg.power;
        cand_valid = !(take_a && take_b) || (cand_coeff != '0);
    end

    // A new term releases the one held back; the final word takes the last flag.
    assign push_pend = cmd.step && cand_valid && pend_valid_reg;

    // Indices and the held-back term.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ia_reg         <= '0;
            ib_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            ia_reg         <= '0;
            ib_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            ia_reg <= ia_reg + CNT_W'(take_a);
            ib_reg <= ib_reg + CNT_W'(take_b);
            if (cand_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && cand_valid)
        begin
            pend_coeff_reg <= cand_coeff;
            pend_power_reg <= cand_power;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_pend || cmd.finish || cmd.fail)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_pend)
        begin
            out_coeff_reg <= pend_coeff_reg;
            out_power_reg <= pend_power_reg;
            out_has_reg   <= 1'b1;
            out_err_reg   <= ERR_NONE;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_coeff_reg <= pend_valid_reg ? pend_coeff_reg : '0;
            out_power_reg <= pend_valid_reg ? pend_power_reg : '0;
            out_has_reg   <= pend_valid_reg;
            out_err_reg   <= ERR_NONE;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.fail)
        begin
            out_coeff_reg <= '0;
            out_power_reg <= '0;
            out_has_reg   <= 1'b0;
            out_err_reg   <= cmd.fail_code;
            out_last_reg  <= 1'b1;
        end
    end

    assign status.overflow   = overflow_reg;
    assign status.bad_input  = unordered_reg || (count_a_reg == '0) || (count_b_reg == '0);
    assign status.merge_done = !a_left && !b_left;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign coeff_sum = out_coeff_reg;
    assign power_out = out_power_reg;
    assign has_term  = out_has_reg;
    assign error     = out_err_reg;
    assign last      = out_last_reg;

endmodule

// ===== rtl/sparse_polynomial_add_unit.sv =====
// Channel | Handshake              | Word fields
// --------+------------------------+------------------------------------------
// input   | in_valid / in_ready    | kind, poly_sel, coeff, power
// output  | out_valid / out_ready  | coeff_sum, power_out, has_term, error, last
//
// A load word is taken every cycle while no run is in progress.
// A run is accepted in idle; each merge step then passes through a fetch state
// (buffer read) and a merge state (compare and add), one step per term pair or
// single term consumed; the final word follows a last fetch (an index check), then
// the final state gives the final output; an error run gives its word from its error state.
// The registered read of the term buffers is why each merge step has its own fetch state.
// Reset clears counts, flags, controller state and the output valid.
// A stalled output holds the merge; no input word is taken until the run ends.
module sparse_polynomial_add_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic                                  poly_sel,
    input  logic signed [spadd_pkg::COEFF_W-1:0]  coeff,
    input  logic signed [spadd_pkg::POWER_W-1:0]  power,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [spadd_pkg::SUM_W-1:0]    coeff_sum,
    output logic signed [spadd_pkg::POWER_W-1:0]  power_out,
    output logic                                  has_term,
    output logic [1:0]                            error,
    output logic                                  last
);
    import spadd_pkg::*;

    spadd_cmd_t    cmd;
    spadd_status_t status;

    // Sequencer.
    spadd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    // Buffers, merge datapath and output register.
    spadd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .poly_sel  (poly_sel),
        .coeff     (coeff),
        .power     (power),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coeff_sum (coeff_sum),
        .power_out (power_out),
        .has_term  (has_term),
        .error     (error),
        .last      (last)
    );

endmodule

// ===== rtl/spadd_checker.sv =====
module spadd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [spadd_pkg::SUM_W-1:0]    coeff_sum,
    input logic signed [spadd_pkg::POWER_W-1:0]  power_out,
    input logic                                  has_term,
    input logic [1:0]                            error,
    input logic                                  last
);
    import spadd_pkg::*;

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coeff_sum) && $stable(power_out)
            && $stable(has_term) && $stable(error) && $stable(last))
    else $error("output word changed while stalled");

    // A word without a term carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_term |-> (coeff_sum == '0) && (power_out == '0))
    else $error("empty word has nonzero fields");

    // An error word ends its run and carries no term.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != ERR_NONE) |-> last && !has_term)
    else $error("error word not final or carries a term");

    // A term word never reports an error, and empty words always end a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_term |-> (error == ERR_NONE))
    else $error("term word reports an error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_term |-> last)
    else $error("empty word not marked last");

endmodule

bind sparse_polynomial_add_unit spadd_checker u_spadd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coeff_sum (coeff_sum),
    .power_out (power_out),
    .has_term  (has_term),
    .error     (error),
    .last      (last)
);
